@@ src/ooram_pkg.sv @@
// Shared types, codes and note helper functions for the out-of-range alarm monitor.
package ooram_pkg;

  // Alarm states, also the event codes of state notes
  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_HIGH   = 2'd1;
  localparam logic [1:0] ST_LOW    = 2'd2;
  localparam logic [1:0] ST_FAULT  = 2'd3;

  localparam logic [2:0] PEND_NONE    = 3'd4;
  localparam logic [2:0] CODE_OVERDUE = 3'd4;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;
  localparam logic [1:0] KIND_MAINT  = 2'd3;

  localparam logic [2:0] REG_HIGH_LIMIT = 3'd0;
  localparam logic [2:0] REG_LOW_LIMIT  = 3'd1;
  localparam logic [2:0] REG_DEAD_BAND  = 3'd2;
  localparam logic [2:0] REG_DELAY      = 3'd3;
  localparam logic [2:0] REG_ESCALATE   = 3'd4;

  localparam int NOTE_CAP   = 2;
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [31:0] note_time;
    logic [2:0]  event_code;
    logic [31:0] note_value;
    logic [1:0]  current_state;
    logic        last_note;
  } note_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] code0;
    logic [2:0] code1;
  } note_list_t;

  // Working copy of the alarm state while one event is evaluated
  typedef struct packed {
    logic [1:0]  st;
    logic [2:0]  pt;
    logic [1:0]  ns;
    logic        ua;
    logic        esc;
    logic        mnt;
    logic [31:0] ps;
    logic [31:0] es;
    note_list_t  nl;
  } alarm_ctx_t;

  function automatic note_list_t put_note(input note_list_t nl, input logic mute,
                                          input logic [2:0] code);
    note_list_t r;
    r = nl;
    if (!mute && (r.cnt < 2'(NOTE_CAP))) begin
      if (r.cnt == 2'd0) r.code0 = code;
      else r.code1 = code;
      r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic alarm_ctx_t announce(input alarm_ctx_t c, input logic [31:0] now,
                                          input logic [1:0] s);
    alarm_ctx_t r;
    r = c;
    r.nl = put_note(r.nl, r.mnt, {1'b0, s});
    r.ns = s;
    if ((s == ST_HIGH) || (s == ST_LOW)) begin
      r.ua  = 1'b1;
      r.es  = now;
      r.esc = 1'b0;
    end
    return r;
  endfunction

  function automatic alarm_ctx_t go_state(input alarm_ctx_t c, input logic [31:0] now,
                                          input logic [1:0] s);
    alarm_ctx_t r;
    r = c;
    r.st = s;
    if (!r.mnt) r = announce(r, now, s);
    return r;
  endfunction

endpackage

@@ src/out_of_range_alarm_monitor.sv @@
// Out-of-range alarm monitor: event register, single-pass evaluation, note queue.
// Path: an event is held in the input register, evaluated there, and its notes are written
// to the note queue, which shows them on out_tvalid in order.
// Throughput, out_tready high: one event per cycle while events give at most one note and
// the queue has room for two; two-note events are bound by the one-note-per-cycle queue.
// Reset: synchronous, active low; clears alarm state, registers and the note queue.
module out_of_range_alarm_monitor (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // now_time[31:0], sample_value[63:32], fault_flag[64],
                                  // maint_on[65], zero[71:66]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // note_time[31:0], note_value[63:32],
                                  // current_state[65:64], zero[71:66]
  output logic [2:0]  out_tuser,  // event_code[2:0]
  output logic        out_tlast,  // last_note
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic signed [31:0] high_limit_r, low_limit_r;
  logic [30:0]        dead_band_r;
  logic [31:0]        delay_r, escalate_r;
  logic [2:0]         reg_idx;

  // input register
  logic        in_valid_r;
  logic [1:0]  kind_r;
  logic [31:0] now_r;
  logic [31:0] sample_r;
  logic        fault_r, maint_on_r;

  // alarm state
  logic [31:0] latest_r, last_value_r;
  ooram_pkg::alarm_ctx_t ctx_r;

  // note queue
  ooram_pkg::note_t fifo_r [ooram_pkg::FIFO_DEPTH];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  fifo_cnt_r, fifo_cnt_nxt;
  logic        pop;

  // evaluation
  logic        proc, old_ev, hi_c, lo_c, do_timer;
  logic signed [32:0] val_x, hi_db_x, lo_db_x, hi_x, lo_x;
  logic [31:0] now_ps, now_es;
  logic [31:0] last_value_nxt;
  ooram_pkg::alarm_ctx_t c0, c1, c2, c3, ctx_nxt;
  logic [2:0]  tgt;
  logic [1:0]  n_notes;
  ooram_pkg::note_t note0, note1;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_limit_r <= '0;
      low_limit_r  <= '0;
      dead_band_r  <= '0;
      delay_r      <= '0;
      escalate_r   <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (reg_idx)
        ooram_pkg::REG_HIGH_LIMIT: high_limit_r <= cfg_pwdata;
        ooram_pkg::REG_LOW_LIMIT:  low_limit_r  <= cfg_pwdata;
        ooram_pkg::REG_DEAD_BAND:  dead_band_r  <= cfg_pwdata[30:0];
        ooram_pkg::REG_DELAY:      delay_r      <= cfg_pwdata;
        ooram_pkg::REG_ESCALATE:   escalate_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ooram_pkg::REG_HIGH_LIMIT: cfg_prdata = high_limit_r;
      ooram_pkg::REG_LOW_LIMIT:  cfg_prdata = low_limit_r;
      ooram_pkg::REG_DEAD_BAND:  cfg_prdata = {1'b0, dead_band_r};
      ooram_pkg::REG_DELAY:      cfg_prdata = delay_r;
      ooram_pkg::REG_ESCALATE:   cfg_prdata = escalate_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  // room for a full pair of notes is needed before an event is evaluated
  assign proc      = in_valid_r && (fifo_cnt_r <= 3'(ooram_pkg::FIFO_DEPTH - ooram_pkg::NOTE_CAP));
  assign in_tready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else if (in_tready) in_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r     <= in_tuser;
      now_r      <= in_tdata[31:0];
      sample_r   <= in_tdata[63:32];
      fault_r    <= in_tdata[64];
      maint_on_r <= in_tdata[65];
    end
  end

  // ---------------- event evaluation ----------------
  assign val_x   = {sample_r[31], sample_r};
  assign hi_x    = {high_limit_r[31], high_limit_r};
  assign lo_x    = {low_limit_r[31], low_limit_r};
  assign hi_db_x = hi_x - $signed({2'b00, dead_band_r});
  assign lo_db_x = lo_x + $signed({2'b00, dead_band_r});
  assign hi_c    = val_x > hi_x;
  assign lo_c    = val_x < lo_x;
  assign old_ev  = now_r < latest_r;
  assign do_timer = !((kind_r == ooram_pkg::KIND_SAMPLE) && fault_r);

  always_comb begin
    c0      = ctx_r;
    c0.nl   = '0;
    tgt     = ooram_pkg::PEND_NONE;
    // sample handling
    if (kind_r == ooram_pkg::KIND_SAMPLE) begin
      if (fault_r) begin
        c0.pt = ooram_pkg::PEND_NONE;
        if (c0.st != ooram_pkg::ST_FAULT)
          c0 = ooram_pkg::go_state(c0, now_r, ooram_pkg::ST_FAULT);
      end else begin
        if (c0.st == ooram_pkg::ST_FAULT) begin
          c0.pt = ooram_pkg::PEND_NONE;
          c0 = ooram_pkg::go_state(c0, now_r, ooram_pkg::ST_NORMAL);
        end
        case (c0.st)
          ooram_pkg::ST_NORMAL: begin
            if (hi_c) tgt = {1'b0, ooram_pkg::ST_HIGH};
            else if (lo_c) tgt = {1'b0, ooram_pkg::ST_LOW};
          end
          ooram_pkg::ST_HIGH: begin
            if (lo_c) tgt = {1'b0, ooram_pkg::ST_LOW};
            else if (val_x < hi_db_x) tgt = {1'b0, ooram_pkg::ST_NORMAL};
          end
          ooram_pkg::ST_LOW: begin
            if (hi_c) tgt = {1'b0, ooram_pkg::ST_HIGH};
            else if (val_x > lo_db_x) tgt = {1'b0, ooram_pkg::ST_NORMAL};
          end
          default: tgt = ooram_pkg::PEND_NONE;
        endcase
        if (tgt == ooram_pkg::PEND_NONE) begin
          c0.pt = ooram_pkg::PEND_NONE;
        end else if (tgt != c0.pt) begin
          c0.pt = tgt;
          c0.ps = now_r;
        end
      end
    end
  end

  // pending transition timer
  assign now_ps = now_r - c0.ps;

  always_comb begin
    c1 = c0;
    if (do_timer && (c1.st != ooram_pkg::ST_FAULT) && (c1.pt != ooram_pkg::PEND_NONE) &&
        (now_ps >= delay_r)) begin
      c1.pt = ooram_pkg::PEND_NONE;
      c1 = ooram_pkg::go_state(c1, now_r, c0.pt[1:0]);
    end
  end

  always_comb begin
    c2 = c1;
    case (kind_r)
      ooram_pkg::KIND_ACK: c2.ua = 1'b0;
      ooram_pkg::KIND_MAINT: begin
        if (maint_on_r && !c2.mnt) begin
          c2.mnt = 1'b1;
        end else if (!maint_on_r && c2.mnt) begin
          c2.mnt = 1'b0;
          // catch-up note when the mode ends
          if (c2.st != c2.ns) c2 = ooram_pkg::announce(c2, now_r, c2.st);
        end
      end
      default: ;
    endcase
  end

  assign now_es = now_r - c2.es;

  always_comb begin
    c3 = c2;
    if (c3.ua && !c3.esc && !c3.mnt && (escalate_r != '0) && (now_es >= escalate_r)) begin
      c3.esc = 1'b1;
      c3.nl  = ooram_pkg::put_note(c3.nl, c3.mnt, ooram_pkg::CODE_OVERDUE);
    end
  end

  assign ctx_nxt        = c3;
  assign n_notes        = old_ev ? 2'd0 : c3.nl.cnt;
  assign last_value_nxt = (kind_r == ooram_pkg::KIND_SAMPLE) ? sample_r : last_value_r;

  always_comb begin
    note0.note_time     = now_r;
    note0.event_code    = c3.nl.code0;
    note0.note_value    = last_value_nxt;
    note0.current_state = c3.st;
    note0.last_note     = (n_notes == 2'd1);
    note1               = note0;
    note1.event_code    = c3.nl.code1;
    note1.last_note     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_r     <= '0;
      last_value_r <= '0;
      ctx_r.st     <= ooram_pkg::ST_NORMAL;
      ctx_r.pt     <= ooram_pkg::PEND_NONE;
      ctx_r.ns     <= ooram_pkg::ST_NORMAL;
      ctx_r.ua     <= 1'b0;
      ctx_r.esc    <= 1'b0;
      ctx_r.mnt    <= 1'b0;
      ctx_r.ps     <= '0;
      ctx_r.es     <= '0;
      ctx_r.nl     <= '0;
    end else if (proc && !old_ev) begin
      latest_r     <= now_r;
      last_value_r <= last_value_nxt;
      ctx_r        <= ctx_nxt;
    end
  end

  // ---------------- note queue ----------------
  assign pop          = out_tvalid && out_tready;
  assign fifo_cnt_nxt = fifo_cnt_r + (proc ? {1'b0, n_notes} : 3'd0) - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (proc) wr_ptr_r <= wr_ptr_r + n_notes;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && (n_notes != 2'd0)) fifo_r[wr_ptr_r] <= note0;
    if (proc && (n_notes == 2'd2)) fifo_r[wr_ptr_r + 2'd1] <= note1;
  end

  assign out_tvalid = (fifo_cnt_r != 3'd0);
  assign out_tdata  = {6'd0, fifo_r[rd_ptr_r].current_state, fifo_r[rd_ptr_r].note_value,
                       fifo_r[rd_ptr_r].note_time};
  assign out_tuser  = fifo_r[rd_ptr_r].event_code;
  assign out_tlast  = fifo_r[rd_ptr_r].last_note;

  // ---------------- assertions ----------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= 3'(ooram_pkg::FIFO_DEPTH))
    else $error("note queue overfilled");

  a_fault_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (ctx_r.st == ooram_pkg::ST_FAULT) |-> (ctx_r.pt == ooram_pkg::PEND_NONE))
    else $error("transition pending while in fault");

  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> (latest_r >= $past(latest_r)))
    else $error("latest event time went backwards");

  a_escalate_unacked: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ctx_r.esc) |-> ctx_r.ua)
    else $error("escalation raised without an unacknowledged episode");

  a_old_no_notes: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && old_ev) |=> (fifo_cnt_r <= $past(fifo_cnt_r)))
    else $error("stale event produced a note");

endmodule
